### src/aesbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, tables and round-step functions of the aes block cipher core
package aesbc_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int KEY_ROWS        = ROUND_KEY_WORDS / 4;
    localparam int ROW_W           = $clog2(KEY_ROWS);
    localparam int WORD_IDX_W      = $clog2(ROUND_KEY_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_RUN
    } t_fsm;

    typedef enum logic [2:0] {
        CFG_KEY0,
        CFG_KEY1,
        CFG_KEY2,
        CFG_KEY3,
        CFG_KEY_LEN,
        CFG_MODE
    } t_cfg_idx;

    localparam logic [1:0] KEY_LEN_128 = 2'd0;
    localparam logic [1:0] KEY_LEN_192 = 2'd1;

    localparam logic [2047:0] SBOX_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TAB[{~b, 3'b000} +: 8];
    endfunction

    // inverse of the s-box affine map
    function automatic logic [7:0] inv_affine(input logic [7:0] b);
        return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
    endfunction

    // field inverse recovered from the forward table
    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return inv_affine(sbox(inv_affine(b)));
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        case (n)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte k of the state sits at bits 127-8k downward
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int k = 0; k < 16; k++) begin
            t[127-8*k -: 8] = inv ? inv_sbox(s[127-8*k -: 8]) : sbox(s[127-8*k -: 8]);
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c-r+4)%4)+r) -: 8];
                end else begin
                    t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   a  [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [7:0]   m0 [4];
        logic [7:0]   m1 [4];
        logic [7:0]   m2 [4];
        logic [7:0]   m3 [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = s[127-8*(4*c+r) -: 8];
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
                // coefficients 2,3,1,1 forward and 14,11,13,9 inverse
                m0[r] = inv ? (x8[r] ^ x4[r] ^ x2[r]) : x2[r];
                m1[r] = inv ? (x8[r] ^ x2[r] ^ a[r]) : (x2[r] ^ a[r]);
                m2[r] = inv ? (x8[r] ^ x4[r] ^ a[r]) : a[r];
                m3[r] = inv ? (x8[r] ^ a[r]) : a[r];
            end
            t[127-32*c -: 8]     = m0[0] ^ m1[1] ^ m2[2] ^ m3[3];
            t[119-32*c -: 8]     = m3[0] ^ m0[1] ^ m1[2] ^ m2[3];
            t[111-32*c -: 8]     = m2[0] ^ m3[1] ^ m0[2] ^ m1[3];
            t[103-32*c -: 8]     = m1[0] ^ m2[1] ^ m3[2] ^ m0[3];
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### src/aes_block_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// aes-128/192/256 core: key schedule store in memory banks and one shared round unit
//
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_ready    i_block_high, i_block_low
// out      source     o_out_valid / i_out_ready  o_out_high, o_out_low
// cfg      sink       i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// a block is accepted in idle, then a load state adds the first round key, then the round unit
// runs one round per cycle (the last round held while the output is full), keys read from a registered memory.
// after reset and after every write to register addresses 0 to 5 the key schedule is expanded
// at one word per cycle (44, 52 or 60 words); no block is taken during that time.
// a finished block waits in the output register; the last round holds while it is full.
module aes_block_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata
);
    import aesbc_pkg::*;

    logic [63:0]           r_key [4];
    logic [1:0]            r_klen;
    logic                  r_enc;

    t_fsm                  r_fsm, n_fsm;
    logic [WORD_IDX_W-1:0] r_ki, n_ki;
    logic [2:0]            r_kmod, n_kmod;
    logic [3:0]            r_rci, n_rci;
    logic [31:0]           r_win [8];
    logic [127:0]          r_st, n_st;
    logic                  r_mode, n_mode;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [3:0]            r_cnt, n_cnt;
    logic [127:0]          r_rk;
    logic [31:0]           r_mem [4][KEY_ROWS];
    logic                  r_ovalid, n_ovalid;
    logic [63:0]           r_ohigh, r_olow;

    logic                  cfg_hit;
    logic                  kw_we;
    logic [31:0]           kw_word;
    logic [31:0]           kw_t;
    logic [63:0]           kw_src;
    logic [2:0]            nk_m1;
    logic [3:0]            nr;
    logic [WORD_IDX_W-1:0] last_word;
    logic                  last_rnd;
    logic [127:0]          enc_a, dec_a, round_out;
    logic                  o_load;

    always_comb begin
        unique case (r_klen)
            KEY_LEN_128: begin
                nk_m1 = 3'd3; nr = 4'd10; last_word = WORD_IDX_W'(43);
            end
            KEY_LEN_192: begin
                nk_m1 = 3'd5; nr = 4'd12; last_word = WORD_IDX_W'(51);
            end
            default: begin
                nk_m1 = 3'd7; nr = 4'd14; last_word = WORD_IDX_W'(59);
            end
        endcase
    end

    assign cfg_hit = i_cfg_we && (i_cfg_addr <= CFG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_klen   <= '0;
            r_enc    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KEY0:    r_key[0] <= i_cfg_wdata;
                CFG_KEY1:    r_key[1] <= i_cfg_wdata;
                CFG_KEY2:    r_key[2] <= i_cfg_wdata;
                CFG_KEY3:    r_key[3] <= i_cfg_wdata;
                CFG_KEY_LEN: r_klen   <= i_cfg_wdata[1:0];
                CFG_MODE:    r_enc    <= i_cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // next schedule word: w[i-1] is r_win[0], w[i-nk] is r_win[nk-1]
    always_comb begin
        kw_src = r_key[r_ki[2:1]];
        kw_t   = r_win[0];
        if (r_kmod == 3'd0) begin
            kw_t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {rcon(r_rci), 24'h0};
        end else if (nk_m1 == 3'd7 && r_kmod == 3'd4) begin
            kw_t = sub_word(r_win[0]);
        end
        if (r_ki <= WORD_IDX_W'(nk_m1)) begin
            kw_word = r_ki[0] ? kw_src[31:0] : kw_src[63:32];
        end else begin
            kw_word = r_win[nk_m1] ^ kw_t;
        end
    end

    // shared round unit
    assign last_rnd = (r_cnt == nr);
    assign enc_a    = shift_rows(sub_bytes(r_st, 1'b0), 1'b0);
    assign dec_a    = sub_bytes(shift_rows(r_st, 1'b1), 1'b1) ^ r_rk;
    always_comb begin
        if (r_mode) begin
            round_out = (last_rnd ? enc_a : mix_columns(enc_a, 1'b0)) ^ r_rk;
        end else begin
            round_out = last_rnd ? dec_a : mix_columns(dec_a, 1'b1);
        end
    end

    always_comb begin
        n_fsm    = r_fsm;
        n_ki     = r_ki;
        n_kmod   = r_kmod;
        n_rci    = r_rci;
        n_st     = r_st;
        n_mode   = r_mode;
        n_row    = r_row;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        kw_we    = 1'b0;
        o_load   = 1'b0;
        unique case (r_fsm)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_st   = {i_block_high, i_block_low};
                    n_mode = r_enc;
                    n_row  = r_enc ? '0 : ROW_W'(nr);
                    n_fsm  = ST_LOAD;
                end
            end
            ST_EXPAND: begin
                kw_we  = 1'b1;
                n_ki   = r_ki + 1'b1;
                if (r_kmod == nk_m1) begin
                    n_kmod = '0;
                    n_rci  = r_rci + 1'b1;
                end else begin
                    n_kmod = r_kmod + 1'b1;
                end
                if (r_ki == last_word) begin
                    n_fsm = ST_IDLE;
                end
            end
            ST_LOAD: begin
                n_st  = r_st ^ r_rk;
                n_cnt = 4'd1;
                n_row = r_mode ? r_row + 1'b1 : r_row - 1'b1;
                n_fsm = ST_RUN;
            end
            ST_RUN: begin
                // last round waits while the output register is still full
                if (!last_rnd || !r_ovalid || i_out_ready) begin
                    n_st = round_out;
                    if (last_rnd) begin
                        n_ovalid = 1'b1;
                        o_load   = 1'b1;
                        n_fsm    = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        n_row = r_mode ? r_row + 1'b1 : r_row - 1'b1;
                    end
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
        if (cfg_hit) begin
            n_fsm  = ST_EXPAND;
            n_ki   = '0;
            n_kmod = '0;
            n_rci  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_EXPAND;
            r_ki     <= '0;
            r_kmod   <= '0;
            r_rci    <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_row    <= '0;
            r_mode   <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_ki     <= n_ki;
            r_kmod   <= n_kmod;
            r_rci    <= n_rci;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_row    <= n_row;
            r_mode   <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
        if (kw_we) begin
            for (int k = 7; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= kw_word;
        end
        if (o_load) begin
            r_ohigh <= round_out[127:64];
            r_olow  <= round_out[63:0];
        end
    end

    // round key store: four word banks, one row per round, registered read
    always_ff @(posedge i_clk) begin
        if (kw_we) begin
            r_mem[r_ki[1:0]][r_ki[WORD_IDX_W-1:2]] <= kw_word;
        end
        for (int b = 0; b < 4; b++) begin
            r_rk[127-32*b -: 32] <= r_mem[b][n_row];
        end
    end

    assign o_in_ready  = (r_fsm == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_high  = r_ohigh;
    assign o_out_low   = r_olow;

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !cfg_hit) |=> (r_fsm == ST_LOAD))
        else $error("accepted block did not start the key load");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_RUN) |-> (r_cnt >= 4'd1 && r_cnt <= nr))
        else $error("round counter out of range");

    a_expand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_EXPAND) |-> (r_ki <= last_word))
        else $error("key expansion ran past the schedule");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_fsm) == ST_RUN))
        else $error("result appeared without a final round");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the aes block cipher core against a behavioral cipher model
module tb;
    import aesbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    localparam logic [7:0] RCON_TAB [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    typedef struct {
        bit          known;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    addr;
        logic [63:0] a;
        logic [63:0] b;
        bit          known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_high;
    logic [63:0] o_out_low;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [63:0] i_cfg_wdata;

    aes_block_cipher_core dut (.*);

    // cipher model state
    logic [63:0] key_reg [4];
    logic [1:0]  key_len;
    logic        enc_mode;
    logic [31:0] sched [60];
    int          n_rounds;
    logic [7:0]  rev_box [256];

    t_block      typed_q [$];
    t_block      cipher_q [$];
    bit          idle_on;
    bit          hold_req;
    int          errors;
    int          n_sent;
    int          n_recv;
    int          n_cfg;
    int          quiet;

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r ^= a;
            a = gf_dbl(a);
        end
        return r;
    endfunction

    function automatic logic [31:0] box_word(input logic [31:0] w);
        return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        int          nk;
        int          total;
        logic [31:0] t;
        nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
        n_rounds = nk + 6;
        total = 4 * (n_rounds + 1);
        for (int i = 0; i < 60; i++) sched[i] = 32'h0;
        for (int i = 0; i < nk; i++) begin
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        end
        for (int i = nk; i < total; i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = box_word({t[23:0], t[31:24]}) ^ {RCON_TAB[(i/nk) % 11], 24'h0};
            end else if (nk > 6 && i % nk == 4) begin
                t = box_word(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
    endfunction

    function automatic void add_key(ref logic [7:0] s [16], input int rnd);
        logic [31:0] w;
        for (int c = 0; c < 4; c++) begin
            w = sched[(rnd*4 + c) % 60];
            for (int r = 0; r < 4; r++) s[4*c+r] ^= w[31-8*r -: 8];
        end
    endfunction

    function automatic void round_steps(ref logic [7:0] s [16], input bit inv, input bit mix);
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] m [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) t[4*((c+r)%4)+r] = s[4*c+r];
                else     t[4*c+r] = s[4*((c+r)%4)+r];
            end
        end
        for (int i = 0; i < 16; i++) s[i] = inv ? rev_box[t[i]] : FWD_BOX[t[i]];
        if (mix) begin
            if (inv) begin
                m = '{8'd14, 8'd11, 8'd13, 8'd9};
            end else begin
                m = '{8'd2, 8'd3, 8'd1, 8'd1};
            end
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
                for (int r = 0; r < 4; r++) begin
                    s[4*c+r] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1])
                             ^ gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
                end
            end
        end
    endfunction

    // inverse rounds apply mix after the key, so decrypt runs its own order here
    function automatic t_block cipher(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0] s [16];
        t_block     res;
        for (int i = 0; i < 8; i++) begin
            s[i]   = hi[63-8*i -: 8];
            s[8+i] = lo[63-8*i -: 8];
        end
        if (enc_mode) begin
            add_key(s, 0);
            for (int r = 1; r < n_rounds; r++) begin
                round_steps(s, 1'b0, 1'b1);
                add_key(s, r);
            end
            round_steps(s, 1'b0, 1'b0);
            add_key(s, n_rounds);
        end else begin
            add_key(s, n_rounds);
            for (int r = n_rounds - 1; r > 0; r--) begin
                round_steps(s, 1'b1, 1'b0);
                add_key(s, r);
                for (int c = 0; c < 4; c++) begin
                    logic [7:0] a [4];
                    for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
                    for (int k = 0; k < 4; k++) begin
                        s[4*c+k] = gf_mul(a[k], 8'd14) ^ gf_mul(a[(k+1)%4], 8'd11)
                                 ^ gf_mul(a[(k+2)%4], 8'd13) ^ gf_mul(a[(k+3)%4], 8'd9);
                    end
                end
            end
            round_steps(s, 1'b1, 1'b0);
            add_key(s, 0);
        end
        res.known = 1'b1;
        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = s[i];
            res.lo[63-8*i -: 8] = s[8+i];
        end
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // transfer monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        t_block pin;
        t_block got;
        t_block want;
        if (i_rst_n) begin
            quiet = quiet + 1;
            if (i_in_valid && o_in_ready) begin
                pin = typed_q.pop_front();
                cipher_q.push_back(pin.known ? pin : cipher(i_block_high, i_block_low));
                n_sent <= n_sent + 1;
                quiet = 0;
            end
            if (o_out_valid && i_out_ready) begin
                quiet = 0;
                n_recv <= n_recv + 1;
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h", $time, o_out_high, o_out_low);
                    errors++;
                end else begin
                    want = cipher_q.pop_front();
                    got.hi = o_out_high;
                    got.lo = o_out_low;
                    if (got.hi !== want.hi) begin
                        $display("%0t: out_high expected %h actual %h", $time, want.hi, got.hi);
                        errors++;
                    end
                    if (got.lo !== want.lo) begin
                        $display("%0t: out_low expected %h actual %h", $time, want.lo, got.lo);
                        errors++;
                    end
                end
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results pending", $time, cipher_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side stalls
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic drain();
        while (cipher_q.size() != 0 || typed_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [63:0] data);
        i_in_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (addr)
            CFG_KEY0:    key_reg[0] = data;
            CFG_KEY1:    key_reg[1] = data;
            CFG_KEY2:    key_reg[2] = data;
            CFG_KEY3:    key_reg[3] = data;
            CFG_KEY_LEN: key_len = data[1:0];
            CFG_MODE:    enc_mode = data[0];
            default:     ;
        endcase
        build_schedule();
        @(posedge i_clk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input t_block pin);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        typed_q.push_back(pin);
        i_in_valid   <= 1'b1;
        i_block_high <= hi;
        i_block_low  <= lo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    t_row rows [$];

    initial begin
        t_block none;
        t_block pin;
        none.known = 1'b0;
        for (int i = 0; i < 256; i++) rev_box[FWD_BOX[i]] = i[7:0];
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        key_len  = KEY_LEN_128;
        enc_mode = 1'b0;
        build_schedule();
        errors = 0;
        n_sent = 0;
        n_recv = 0;
        n_cfg  = 0;
        quiet  = 0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_block_high = '0;
        i_block_low  = '0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = CFG_KEY0;
        i_cfg_wdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, known-answer vectors, key-length aliases, ignored indexes
        rows = '{
            '{0, CFG_KEY0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, '1, '1, 0, 64'h0, 64'h0},
            '{1, CFG_MODE, 64'h1, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
            '{1, CFG_KEY0, 64'h0001020304050607, 64'h0, 0, 64'h0, 64'h0},
            '{1, CFG_KEY1, 64'h08090a0b0c0d0e0f, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
            '{1, CFG_MODE, 64'h0, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
              1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            '{1, CFG_KEY2, 64'h1011121314151617, 64'h0, 0, 64'h0, 64'h0},
            '{1, CFG_KEY_LEN, 64'h1, 64'h0, 0, 64'h0, 64'h0},
            '{1, CFG_MODE, 64'h1, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
            '{1, CFG_KEY3, 64'h18191a1b1c1d1e1f, 64'h0, 0, 64'h0, 64'h0},
            '{1, CFG_KEY_LEN, 64'h2, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h0011223344556677, 64'h8899aabbccddeeff,
              1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
            '{1, CFG_MODE, 64'hfffffffffffffffe, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
              1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            '{1, CFG_KEY_LEN, 64'h3, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
              1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            '{1, t_cfg_idx'(6), '1, 64'h0, 0, 64'h0, 64'h0},
            '{1, t_cfg_idx'(7), '1, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089,
              1, 64'h0011223344556677, 64'h8899aabbccddeeff},
            '{1, CFG_KEY0, '1, 64'h0, 0, 64'h0, 64'h0},
            '{1, CFG_KEY_LEN, 64'hfffffffffffffffd, 64'h0, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, '1, '1, 0, 64'h0, 64'h0},
            '{0, CFG_KEY0, 64'h8000000000000001, 64'h7ffffffffffffffe, 0, 64'h0, 64'h0}
        };
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_reg(rows[i].addr, rows[i].a);
            end else begin
                pin = none;
                if (rows[i].known) begin
                    pin.known = 1'b1;
                    pin.hi = rows[i].exp_hi;
                    pin.lo = rows[i].exp_lo;
                end
                send_block(rows[i].a, rows[i].b, pin);
            end
        end

        // random phases: mode and key length written each phase, key words at random, last phase without idling
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) idle_on = 1'b0;
            for (int r = CFG_KEY0; r <= CFG_KEY3; r++) begin
                if (ph < 2 || $urandom_range(0, 2) != 0) begin
                    write_reg(r[2:0], (ph == 1) ? '1 : rand_word());
                end
            end
            write_reg(CFG_KEY_LEN, 64'((ph < 4) ? ph : $urandom_range(0, 3)));
            write_reg(CFG_MODE, 64'((ph < 2) ? ph : $urandom_range(0, 1)));
            for (int k = 0; k < 148; k++) begin
                if (ph == 3 && k == 10) hold_req = 1'b1;
                if (ph == 5 && k == 70) begin
                    i_in_valid <= 1'b0;
                    drain();
                end
                send_block(rand_word(), rand_word(), none);
            end
        end

        i_in_valid <= 1'b0;
        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d blocks, %0d register writes, all key lengths, both modes",
                 n_sent, n_cfg);
        $display("results checked %0d, mismatches %0d", n_recv, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
